### hw/rtl/tsr_pkg.sv
// Package for the serial trackball report core: payload types, constants and
// the movement code functions. It depends on nothing else.
package tsr_pkg;

    localparam int STREAM_BITS = 32;
    localparam int MASK_BITS = 23;

    typedef logic [STREAM_BITS-1:0] stream_t;
    typedef logic [MASK_BITS-1:0] mask_t;
    typedef logic [1:0] cfg_index_t;
    typedef logic signed [9:0] delta_t;

    localparam cfg_index_t CFG_CONNECTED = 2'd0;
    localparam cfg_index_t CFG_REVERSED = 2'd1;
    localparam cfg_index_t CFG_LOWSPEED = 2'd2;

    localparam mask_t CONNECTED_RESET = 23'h080000;
    localparam mask_t REVERSED_RESET = 23'h020000;
    localparam mask_t LOWSPEED_RESET = 23'h040000;
    localparam logic [15:0] REPORT_IDLE = 16'hFF00;

    localparam logic [7:0] X_MAX = 8'd255;
    localparam logic [7:0] Y_MAX = 8'd239;

    localparam delta_t THR_NORMAL [5] = '{10'sd0, 10'sd4, 10'sd8, 10'sd16, 10'sd24};
    localparam delta_t THR_LOW [5] = '{10'sd1, 10'sd16, 10'sd32, 10'sd48, 10'sd56};

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic        op;
        logic        port_select;
        logic [7:0]  write_data;
        logic        sample_valid;
        logic [7:0]  buttons;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic        rev_request;
        logic        slow_request;
    } in_item_t;

    typedef struct packed {
        logic [1:0] read_value;
    } out_item_t;

    // Level of a delta magnitude against the table: 1 to 5, growing with the magnitude;
    // the dead zone is checked in x_code before this is called.
    function automatic logic [2:0] level(input delta_t mag, input logic low);
        delta_t t1;
        delta_t t2;
        delta_t t3;
        delta_t t4;
        t1 = low ? THR_LOW[1] : THR_NORMAL[1];
        t2 = low ? THR_LOW[2] : THR_NORMAL[2];
        t3 = low ? THR_LOW[3] : THR_NORMAL[3];
        t4 = low ? THR_LOW[4] : THR_NORMAL[4];
        if (mag >= t4)
            return 3'd5;
        else if (mag >= t3)
            return 3'd4;
        else if (mag >= t2)
            return 3'd3;
        else if (mag >= t1)
            return 3'd2;
        else
            return 3'd1;
    endfunction

    function automatic logic [3:0] x_code(input delta_t d, input logic low);
        delta_t t0;
        logic [2:0] lv;
        t0 = low ? THR_LOW[0] : THR_NORMAL[0];
        if (d > t0) begin
            lv = level(d, low);
            case (lv)
                3'd5:    return 4'h1;
                3'd4:    return 4'h9;
                3'd3:    return 4'h5;
                3'd2:    return 4'h3;
                default: return 4'h7;
            endcase
        end else if (d < -t0) begin
            lv = level(-d, low);
            case (lv)
                3'd5:    return 4'h6;
                3'd4:    return 4'h2;
                3'd3:    return 4'h4;
                3'd2:    return 4'h8;
                default: return 4'h0;
            endcase
        end
        return 4'hF;
    endfunction

    // The Y code is the X code of the opposite direction.
    function automatic logic [3:0] y_code(input delta_t d, input logic low);
        return x_code(-d, low);
    endfunction

endpackage

### hw/rtl/tsr_ifs.sv
// Handshake channels of the serial trackball report core: input items,
// result items and configuration writes. Depends on tsr_pkg.
interface tsr_in_if;
    logic              valid;
    logic              ready;
    tsr_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tsr_out_if;
    logic               valid;
    logic               ready;
    tsr_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tsr_cfg_if;
    logic                valid;
    logic                ready;
    tsr_pkg::cfg_index_t index;
    tsr_pkg::mask_t      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/trackball_serial_report_core.sv
// Serial trackball controller port: strobe latch, report builder and shift stream.
// Depends on tsr_pkg and the channel interfaces in tsr_ifs.sv.
//
//   channel  | direction | payload
//   in_ch    | sink      | op, port_select, write_data, sample, buttons, positions, modes
//   out_ch   | source    | read_value
//   cfg      | sink      | index, data (23-bit flag mask)
//
// Each item is handled in the cycle it is accepted, so one item per cycle is taken.
// A read leaves its result in an output register; the input stalls only while that
// register is full and not being taken. Writes produce no result.
// Configuration writes are always accepted and apply to the next report built.
// Reset clears the strobe, stream and positions and loads the idle report.
module trackball_serial_report_core (
    input  logic       clk,
    input  logic       rst_n,
    tsr_in_if.sink     in_ch,
    tsr_out_if.source  out_ch,
    tsr_cfg_if.sink    cfg
);

    tsr_pkg::mask_t   connected_reg;
    tsr_pkg::mask_t   reversed_reg;
    tsr_pkg::mask_t   lowspeed_reg;
    logic             strobe_reg;
    tsr_pkg::stream_t stream_reg;
    tsr_pkg::stream_t stream_next;
    tsr_pkg::stream_t report_reg;
    tsr_pkg::stream_t report_next;
    logic [7:0]       last_x_reg;
    logic [7:0]       last_x_next;
    logic [7:0]       last_y_reg;
    logic [7:0]       last_y_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [1:0]       read_value_reg;
    logic [1:0]       read_value_next;

    logic             in_fire;
    logic             is_read;
    logic             falling;
    logic [7:0]       new_x;
    logic [7:0]       new_y;
    tsr_pkg::delta_t  dx;
    tsr_pkg::delta_t  dy;
    tsr_pkg::mask_t   bits;
    tsr_pkg::stream_t built;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire = in_ch.valid && in_ch.ready;
    assign is_read = in_ch.data.op == tsr_pkg::OP_READ;
    assign falling = !is_read && strobe_reg && !in_ch.data.write_data[0];
    assign cfg.ready = 1'b1;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data.read_value = read_value_reg;

    always_comb
    begin
        new_x = (in_ch.data.pos_x > 12'(tsr_pkg::X_MAX)) ? tsr_pkg::X_MAX
                                                        : in_ch.data.pos_x[7:0];
        new_y = (in_ch.data.pos_y > 12'(tsr_pkg::Y_MAX)) ? tsr_pkg::Y_MAX
                                                        : in_ch.data.pos_y[7:0];
        dx = tsr_pkg::delta_t'({2'b00, last_x_reg}) - tsr_pkg::delta_t'({2'b00, new_x});
        dy = tsr_pkg::delta_t'({2'b00, last_y_reg}) - tsr_pkg::delta_t'({2'b00, new_y});
        bits = {15'd0, in_ch.data.buttons} | connected_reg
             | (in_ch.data.rev_request ? reversed_reg : '0)
             | (in_ch.data.slow_request ? lowspeed_reg : '0)
             | {7'd0, tsr_pkg::y_code(dy, in_ch.data.slow_request),
                tsr_pkg::x_code(dx, in_ch.data.slow_request), 8'd0};
        built = tsr_pkg::STREAM_BITS'({bits, 1'b0});
    end

    always_comb
    begin
        stream_next = stream_reg;
        report_next = report_reg;
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        read_value_next = read_value_reg;
        if (in_fire) begin
            if (is_read) begin
                out_valid_next = 1'b1;
                if (!in_ch.data.port_select) begin
                    read_value_next = {stream_reg[1], 1'b0};
                    stream_next = stream_reg >> 1;
                end else begin
                    read_value_next = 2'b00;
                end
            end else if (falling) begin
                if (in_ch.data.sample_valid) begin
                    report_next = built;
                    last_x_next = new_x;
                    last_y_next = new_y;
                end
                stream_next = report_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            connected_reg <= tsr_pkg::CONNECTED_RESET;
            reversed_reg <= tsr_pkg::REVERSED_RESET;
            lowspeed_reg <= tsr_pkg::LOWSPEED_RESET;
            strobe_reg <= 1'b0;
            stream_reg <= '0;
            report_reg <= tsr_pkg::STREAM_BITS'({7'd0, tsr_pkg::REPORT_IDLE}
                                                 | tsr_pkg::CONNECTED_RESET);
            last_x_reg <= '0;
            last_y_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg.valid) begin
                case (cfg.index)
                    tsr_pkg::CFG_CONNECTED: connected_reg <= cfg.data;
                    tsr_pkg::CFG_REVERSED:  reversed_reg <= cfg.data;
                    tsr_pkg::CFG_LOWSPEED:  lowspeed_reg <= cfg.data;
                    default:                ;
                endcase
            end
            if (in_fire && !is_read)
                strobe_reg <= in_ch.data.write_data[0];
            stream_reg <= stream_next;
            report_reg <= report_next;
            last_x_reg <= last_x_next;
            last_y_reg <= last_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_value_reg <= read_value_next;
    end

`ifndef SYNTHESIS
    a_read_shifts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && is_read && !in_ch.data.port_select
        |=> stream_reg == ($past(stream_reg) >> 1))
        else $error("stream did not shift on a port 0 read");

    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && falling |=> stream_reg == report_reg)
        else $error("stream did not reload from the report on a falling strobe");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !is_read |=> !out_valid_reg)
        else $error("a write produced a result");

    a_read_even: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !read_value_reg[0])
        else $error("read value has bit 0 set");

    a_y_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        last_y_reg <= tsr_pkg::Y_MAX)
        else $error("stored Y position exceeds its clamp");
`endif

endmodule
